// File: rtl/arl_pkg.sv
package arl_pkg;

  // List and tree geometry.
  localparam int MAX_ENTRIES = 32;
  localparam int W_SLOTS     = 32;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int SLOT_W      = $clog2(W_SLOTS);
  localparam int SLOT_X_W    = SLOT_W + 2;

  // Value widths.
  localparam int CHAN_W  = 10;
  localparam int VAL_W   = 10;
  localparam int W_W     = 11;
  localparam int RANGE_W = 11;
  localparam int OFF_W   = 12;
  localparam int ARITH_W = 13;
  localparam int SLOT_OUT_W = 6;
  localparam int STATUS_W   = 2;

  // Scratch RAM: one region of MAX_ENTRIES words per tree depth and side.
  localparam int DEPTH_W     = 4;
  localparam int SCR_AW      = DEPTH_W + 1 + IDX_W;
  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_RANGE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORM_1024    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_CHANNEL = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPLIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [RANGE_W-1:0] rng;
    logic [CNT_W-1:0]   num;
    logic [DEPTH_W-1:0] depth;
    logic               side;
    logic [SLOT_W-1:0]  slot;
    logic               beyond;
  } node_t;

  typedef struct packed {
    logic              we;
    logic [SCR_AW-1:0] addr;
    logic [VAL_W-1:0]  data;
  } scr_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [W_W-1:0]    data;
  } w_wr_t;

  typedef struct packed {
    logic done;
    logic split_err;
  } build_stat_t;

  typedef enum logic [2:0] {
    CS_LOAD,
    CS_BUILD,
    CS_EMIT_RD,
    CS_EMIT_CAP,
    CS_EMIT_HOLD
  } ctl_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_NODE,
    BS_LEAF,
    BS_PIV_RD,
    BS_PIV_CAP,
    BS_PIV_SCAN,
    BS_PART_SCAN,
    BS_FINISH
  } bld_state_t;

  // One conditional add or subtract of the range.
  function automatic logic signed [ARITH_W-1:0] wrap_once(
    input logic signed [ARITH_W-1:0] x,
    input logic [RANGE_W-1:0]        r
  );
    logic signed [ARITH_W-1:0] rs;
    rs = $signed({{(ARITH_W-RANGE_W){1'b0}}, r});
    if (x < 0) begin
      wrap_once = x + rs;
    end else if (x >= rs) begin
      wrap_once = x - rs;
    end else begin
      wrap_once = x;
    end
  endfunction

  // Largest power of two not above v.
  function automatic logic [CNT_W-1:0] pow2_floor(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] res;
    res = CNT_W'(1);
    for (int b = 0; b < CNT_W; b++) begin
      if (v[b]) begin
        res = CNT_W'(1) << b;
      end
    end
    pow2_floor = res;
  endfunction

endpackage

// File: rtl/arl_if.sv
interface arl_list_if import arl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic              last_entry;
  modport source(output valid, channel, last_entry, input ready);
  modport sink(input valid, channel, last_entry, output ready);
endinterface

interface arl_w_if import arl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [W_W-1:0]        w_value;
  logic [SLOT_OUT_W-1:0] w_slot;
  logic                  last_result;
  logic                  base_present;
  logic [STATUS_W-1:0]   status;
  modport source(output valid, w_value, w_slot, last_result, base_present, status,
                 input ready);
  modport sink(input valid, w_value, w_slot, last_result, base_present, status,
               output ready);
endinterface

interface arl_cfg_if import arl_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/arl_scratch_ram.sv
module arl_scratch_ram import arl_pkg::*; (
  input  logic              clk,
  input  scr_wr_t           wr,
  input  logic [SCR_AW-1:0] rd_addr,
  output logic [VAL_W-1:0]  rd_data
);

  logic [VAL_W-1:0] mem [2**SCR_AW];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/arl_w_store.sv
module arl_w_store import arl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  w_wr_t             wr,
  input  logic [SLOT_W-1:0] rd_addr,
  output logic [W_W-1:0]    rd_data
);

  logic [W_W-1:0]     mem [W_SLOTS];
  logic [W_SLOTS-1:0] vld;

  // Slots never written since the last clear read as zero.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr.we) begin
      vld[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
  end

endmodule

// File: rtl/arl_builder.sv
module arl_builder import arl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [RANGE_W-1:0] top_range,
  input  logic [CNT_W-1:0]   count,
  output build_stat_t        stat,
  output logic [SCR_AW-1:0]  scr_rd_addr,
  input  logic [VAL_W-1:0]   scr_rd_data,
  output scr_wr_t            scr_wr,
  output w_wr_t              w_wr
);

  bld_state_t state, state_next;

  node_t            node;
  node_t            stack [STACK_DEPTH];
  logic [SP_W-1:0]  sp;
  logic [CNT_W-1:0] piv_i;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] left_n;
  logic [VAL_W-1:0] vi;
  logic [OFF_W-1:0] lo_off;
  logic [OFF_W-1:0] ro_off;
  logic             pass;
  logic             split_err;

  logic [RANGE_W-1:0]        rng_m1;
  logic [VAL_W-1:0]          delta;
  logic [VAL_W-1:0]          half;
  logic signed [ARITH_W-1:0] rd_x, vi_x, delta_x, half_x;
  logic signed [ARITH_W-1:0] piv_dist, lo_w, ro_w, part_dist;
  logic [OFF_W-1:0]          off;
  logic                      scan_last;
  logic                      hit;
  logic                      take;
  logic [CNT_W-1:0]          cnt_hit;
  logic [CNT_W-1:0]          cnt_take;
  logic                      piv_found;
  logic                      last_cand;
  logic [CNT_W-1:0]          slot_step;
  logic [SLOT_X_W-1:0]       c1, c2;
  node_t                     left_node, right_node;
  logic [DEPTH_W-1:0]        child_depth;

  // Node arithmetic.
  always_comb begin
    rng_m1    = node.rng - RANGE_W'(1);
    delta     = rng_m1[RANGE_W-1:1];
    half      = node.rng[RANGE_W-1:1];
    rd_x      = $signed({{(ARITH_W-VAL_W){1'b0}}, scr_rd_data});
    vi_x      = $signed({{(ARITH_W-VAL_W){1'b0}}, vi});
    delta_x   = $signed({{(ARITH_W-VAL_W){1'b0}}, delta});
    half_x    = $signed({{(ARITH_W-VAL_W){1'b0}}, half});
    off       = pass ? ro_off : lo_off;
    piv_dist  = wrap_once(rd_x - vi_x, node.rng);
    part_dist = wrap_once(rd_x - $signed({1'b0, off}), node.rng);
    lo_w      = wrap_once(vi_x + delta_x + ARITH_W'(1), node.rng);
    ro_w      = wrap_once(vi_x + ARITH_W'(1), node.rng);
    scan_last = (scan_idx == node.num);
    hit       = (scan_idx != '0) && (piv_dist <= delta_x);
    take      = (scan_idx != '0) && !part_dist[ARITH_W-1] && (part_dist < half_x) &&
                (cnt < CNT_W'(MAX_ENTRIES));
    cnt_hit   = cnt + CNT_W'(hit);
    cnt_take  = cnt + CNT_W'(take);
    piv_found = (cnt_hit == ((node.num - CNT_W'(1)) >> 1) + CNT_W'(1));
    last_cand = (piv_i + CNT_W'(1) == node.num);

    slot_step   = pow2_floor({1'b0, node.slot} + CNT_W'(1));
    c1          = SLOT_X_W'(node.slot) + SLOT_X_W'(slot_step);
    c2          = SLOT_X_W'(node.slot) + (SLOT_X_W'(slot_step) << 1);
    child_depth = node.depth + DEPTH_W'(1);

    left_node.rng    = {1'b0, half};
    left_node.num    = left_n;
    left_node.depth  = child_depth;
    left_node.side   = 1'b0;
    left_node.slot   = c1[SLOT_W-1:0];
    left_node.beyond = node.beyond || (c1 >= SLOT_X_W'(W_SLOTS));

    right_node.rng    = {1'b0, delta};
    right_node.num    = cnt_take;
    right_node.depth  = child_depth;
    right_node.side   = 1'b1;
    right_node.slot   = c2[SLOT_W-1:0];
    right_node.beyond = node.beyond || (c2 >= SLOT_X_W'(W_SLOTS));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (start) state_next = BS_NODE;
      end
      BS_NODE: begin
        priority if (node.num == '0) state_next = BS_FINISH;
        else if (node.num == CNT_W'(1)) state_next = BS_LEAF;
        else if (node.rng < RANGE_W'(2)) state_next = BS_FINISH;
        else state_next = BS_PIV_RD;
      end
      BS_LEAF:    state_next = BS_FINISH;
      BS_PIV_RD:  state_next = BS_PIV_CAP;
      BS_PIV_CAP: state_next = BS_PIV_SCAN;
      BS_PIV_SCAN: begin
        if (scan_last) begin
          priority if (piv_found) state_next = BS_PART_SCAN;
          else if (last_cand) state_next = BS_FINISH;
          else state_next = BS_PIV_RD;
        end
      end
      BS_PART_SCAN: begin
        if (scan_last && pass) state_next = BS_NODE;
      end
      BS_FINISH: begin
        state_next = (sp == '0) ? BS_IDLE : BS_NODE;
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    scr_rd_addr = {node.depth, node.side, scan_idx[IDX_W-1:0]};
    scr_wr      = '0;
    w_wr        = '0;
    stat.done      = 1'b0;
    stat.split_err = split_err;
    unique case (state)
      BS_NODE: begin
        scr_rd_addr = {node.depth, node.side, IDX_W'(0)};
      end
      BS_PIV_RD: begin
        scr_rd_addr = {node.depth, node.side, piv_i[IDX_W-1:0]};
      end
      BS_LEAF: begin
        w_wr.we   = !node.beyond;
        w_wr.addr = node.slot;
        w_wr.data = {1'b0, scr_rd_data} + W_W'(1);
      end
      BS_PIV_SCAN: begin
        w_wr.we   = scan_last && piv_found && !node.beyond;
        w_wr.addr = node.slot;
        w_wr.data = {1'b0, vi} + W_W'(1);
      end
      BS_PART_SCAN: begin
        scr_wr.we   = take;
        scr_wr.addr = {child_depth, pass, cnt[IDX_W-1:0]};
        scr_wr.data = part_dist[VAL_W-1:0];
      end
      BS_FINISH: begin
        stat.done = (sp == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      sp        <= '0;
      split_err <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BS_IDLE: begin
          if (start) begin
            sp        <= '0;
            split_err <= 1'b0;
          end
        end
        BS_NODE: begin
          if (node.num > CNT_W'(1) && node.rng < RANGE_W'(2)) split_err <= 1'b1;
        end
        BS_PIV_SCAN: begin
          if (scan_last && !piv_found && last_cand) split_err <= 1'b1;
        end
        BS_PART_SCAN: begin
          if (scan_last && pass) sp <= sp + SP_W'(1);
        end
        BS_FINISH: begin
          if (sp != '0) sp <= sp - SP_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BS_IDLE: begin
        if (start) begin
          node.rng    <= top_range;
          node.num    <= count;
          node.depth  <= '0;
          node.side   <= 1'b0;
          node.slot   <= '0;
          node.beyond <= 1'b0;
        end
      end
      BS_NODE: piv_i <= '0;
      BS_PIV_CAP: begin
        vi       <= scr_rd_data;
        scan_idx <= '0;
        cnt      <= '0;
      end
      BS_PIV_SCAN: begin
        if (scan_last) begin
          if (piv_found) begin
            lo_off   <= lo_w[OFF_W-1:0];
            ro_off   <= ro_w[OFF_W-1:0];
            pass     <= 1'b0;
            scan_idx <= '0;
            cnt      <= '0;
          end else begin
            piv_i <= piv_i + CNT_W'(1);
          end
        end else begin
          scan_idx <= scan_idx + CNT_W'(1);
          cnt      <= cnt_hit;
        end
      end
      BS_PART_SCAN: begin
        if (scan_last) begin
          if (!pass) begin
            left_n   <= cnt_take;
            pass     <= 1'b1;
            scan_idx <= '0;
            cnt      <= '0;
          end else begin
            stack[sp] <= right_node;
            node      <= left_node;
          end
        end else begin
          scan_idx <= scan_idx + CNT_W'(1);
          cnt      <= cnt_take;
        end
      end
      BS_FINISH: begin
        if (sp != '0) node <= stack[sp - SP_W'(1)];
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/arfcn_range_list_encoder.sv
// Channel-list range encoder: balanced W(i) tree of the channel range formats.
//
// Channels: cfg writes top_range (index 0), form_1024 (index 1) and
// base_channel (index 2); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. list_ch takes one channel per
// beat, one beat per cycle while loading; a beat with last_entry set closes the
// list. w_ch then delivers W_SLOTS beats, one per W slot in order, each carrying
// base_present and status for the whole list. The tree build starts in the cycle
// after the last entry and runs over the scratch RAM, whose single read port
// sets the pace. A node is opened, searched for a split entry and then
// partitioned; a leaf adds a write of its W value and every finished subtree a
// pop of the next node from the stack. Emission steps through read, capture and
// hold for each slot, because each slot is read from the W store and registered
// before it is shown; the next slot is read only after the held one is taken.
// list_ch is not ready during build and emission; the next list starts
// after the final slot beat is taken.
// Reset restores the register defaults and empties the list and W store.
// A receiver stall simply holds the current result beat; nothing is lost.
module arfcn_range_list_encoder import arl_pkg::*; (
  input logic      clk,
  input logic      rst,
  arl_cfg_if.sink  cfg,
  arl_list_if.sink list_ch,
  arl_w_if.source  w_ch
);

  ctl_state_t state, state_next;

  // Configuration registers.
  logic [RANGE_W-1:0] top_range;
  logic               form_1024;
  logic [CHAN_W-1:0]  base_channel;

  // Per-list state.
  logic [CNT_W-1:0]    count;
  logic                base_seen;
  logic [STATUS_W-1:0] err_code;
  logic                start_q;
  logic [SLOT_W-1:0]   emit_idx;

  // Result register.
  logic [W_W-1:0]        w_value_q;
  logic [SLOT_OUT_W-1:0] w_slot_q;
  logic                  last_q;
  logic                  base_q;
  logic [STATUS_W-1:0]   status_q;

  logic              list_acc;
  logic              w_acc;
  logic              is_base;
  logic              emit_last;
  logic [CHAN_W-1:0] sub;
  scr_wr_t           load_wr, bld_wr, scr_wr;
  logic [SCR_AW-1:0] scr_rd_addr;
  logic [VAL_W-1:0]  scr_rd_data;
  w_wr_t             w_wr;
  logic [W_W-1:0]    w_rd_data;
  logic              w_clear;
  build_stat_t       bstat;

  assign list_acc  = list_ch.valid && list_ch.ready;
  assign w_acc     = w_ch.valid && w_ch.ready;
  assign is_base   = (list_ch.channel == base_channel);
  assign emit_last = (emit_idx == SLOT_W'(W_SLOTS - 1));

  // Entries other than the base are rebased modulo 1024 as they are stored;
  // in the 1024 form the offset is one, otherwise it is f0 plus one.
  assign sub = form_1024 ? CHAN_W'(1) : base_channel + CHAN_W'(1);

  always_comb begin
    load_wr.we   = list_acc && !is_base && (count < CNT_W'(MAX_ENTRIES));
    load_wr.addr = {DEPTH_W'(0), 1'b0, count[IDX_W-1:0]};
    load_wr.data = list_ch.channel - sub;
    scr_wr       = (state == CS_LOAD) ? load_wr : bld_wr;
  end

  arl_scratch_ram u_scratch (
    .clk     (clk),
    .wr      (scr_wr),
    .rd_addr (scr_rd_addr),
    .rd_data (scr_rd_data)
  );

  arl_builder u_builder (
    .clk         (clk),
    .rst         (rst),
    .start       (start_q),
    .top_range   (top_range),
    .count       (count),
    .stat        (bstat),
    .scr_rd_addr (scr_rd_addr),
    .scr_rd_data (scr_rd_data),
    .scr_wr      (bld_wr),
    .w_wr        (w_wr)
  );

  arl_w_store u_w_store (
    .clk     (clk),
    .rst     (rst),
    .clear   (w_clear),
    .wr      (w_wr),
    .rd_addr (emit_idx),
    .rd_data (w_rd_data)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      CS_LOAD: begin
        if (list_acc && list_ch.last_entry) state_next = CS_BUILD;
      end
      CS_BUILD: begin
        if (bstat.done) state_next = CS_EMIT_RD;
      end
      CS_EMIT_RD:  state_next = CS_EMIT_CAP;
      CS_EMIT_CAP: state_next = CS_EMIT_HOLD;
      CS_EMIT_HOLD: begin
        if (w_acc) state_next = emit_last ? CS_LOAD : CS_EMIT_RD;
      end
      default: state_next = CS_LOAD;
    endcase
  end

  always_comb begin
    list_ch.ready = (state == CS_LOAD);
    w_ch.valid    = (state == CS_EMIT_HOLD);
    w_clear       = (state == CS_EMIT_HOLD) && w_acc && emit_last;
    cfg.ready     = 1'b1;
  end

  assign w_ch.w_value      = w_value_q;
  assign w_ch.w_slot       = w_slot_q;
  assign w_ch.last_result  = last_q;
  assign w_ch.base_present = base_q;
  assign w_ch.status       = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CS_LOAD;
      top_range    <= RANGE_W'(512);
      form_1024    <= 1'b0;
      base_channel <= '0;
      count        <= '0;
      base_seen    <= 1'b0;
      err_code     <= ST_OK;
      start_q      <= 1'b0;
      emit_idx     <= '0;
    end else begin
      state   <= state_next;
      start_q <= list_acc && list_ch.last_entry;

      if (cfg.valid) begin
        unique case (cfg.index)
          REG_TOP_RANGE:    top_range    <= cfg.data;
          REG_FORM_1024:    form_1024    <= cfg.data[0];
          REG_BASE_CHANNEL: base_channel <= cfg.data[CHAN_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        CS_LOAD: begin
          if (list_acc) begin
            priority if (is_base) base_seen <= 1'b1;
            else if (count < CNT_W'(MAX_ENTRIES)) count <= count + CNT_W'(1);
            else err_code <= ST_OVERFLOW;
          end
        end
        CS_BUILD: begin
          if (bstat.done) begin
            emit_idx <= '0;
            // An overflow outranks a failed split.
            if (bstat.split_err && err_code == ST_OK) err_code <= ST_NO_SPLIT;
          end
        end
        CS_EMIT_HOLD: begin
          if (w_acc) begin
            if (emit_last) begin
              count     <= '0;
              base_seen <= 1'b0;
              err_code  <= ST_OK;
            end else begin
              emit_idx <= emit_idx + SLOT_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == CS_EMIT_CAP) begin
      w_value_q <= w_rd_data;
      w_slot_q  <= SLOT_OUT_W'(emit_idx) + SLOT_OUT_W'(1);
      last_q    <= emit_last;
      base_q    <= base_seen;
      status_q  <= err_code;
    end
  end

endmodule

// File: tb/tb_arfcn_range_list_encoder.sv
module tb_arfcn_range_list_encoder;
  import arl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 500;
  localparam int CHAN_SPAN      = 1024;

  logic clk;
  logic rst;

  arl_cfg_if  cfg();
  arl_list_if list_ch();
  arl_w_if    w_ch();

  arfcn_range_list_encoder dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg.sink),
    .list_ch (list_ch.sink),
    .w_ch    (w_ch.source)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One expected W slot beat.
  typedef struct {
    logic [W_W-1:0]        w_value;
    logic [SLOT_OUT_W-1:0] w_slot;
    logic                  last_result;
    logic                  base_present;
    logic [STATUS_W-1:0]   status;
  } w_beat_t;

  w_beat_t expected_slots[$];

  // Shadow copy of the configuration registers.
  int shadow_range;
  int shadow_form;
  int shadow_base;

  // Shadow copy of the list state.
  int                  held_entries[$];
  logic                held_base_seen;
  logic [STATUS_W-1:0] held_status;
  int                  tree_slots[W_SLOTS];

  int mismatches;
  int beats_checked;
  int lists_closed;
  int items_sent;
  int overflow_lists;
  int split_err_lists;

  // Sender burst shaping.
  int burst_left;

  // Receiver stall pattern.
  int stall_left;
  int calm_left;

  // Watchdog on cycles with no beat on any channel.
  int idle_cycles;

  // A single conditional add or subtract of the range, as the block does it.
  function automatic int wrap_range(int x, int r);
    if (x < 0) begin
      return x + r;
    end
    if (x >= r) begin
      return x - r;
    end
    return x;
  endfunction

  function automatic int pow2_below(int n);
    int p;
    p = 1;
    while (p <= n / 2) begin
      p = p * 2;
    end
    return p;
  endfunction

  function automatic void note_split_error();
    if (held_status == ST_OK) begin
      held_status = ST_NO_SPLIT;
    end
  endfunction

  function automatic void store_slot(int slot, int val);
    if (slot < W_SLOTS) begin
      tree_slots[slot] = val & 32'h7FF;
    end
  endfunction

  // Build one node of the balanced tree and recurse into both halves.
  function automatic void encode_node(int rng, int vals[$], int slot);
    int lefts[$];
    int rights[$];
    int n;
    int delta;
    int half;
    int pivot;
    int cnt;
    int lo;
    int ro;
    int d;
    int step;
    bit found;
    n = vals.size();
    found = 1'b0;
    pivot = 0;
    if (n == 0) begin
      return;
    end
    if (n == 1) begin
      store_slot(slot, 1 + vals[0]);
      return;
    end
    if (rng < 2) begin
      note_split_error();
      return;
    end
    delta = (rng - 1) / 2;
    for (int i = 0; i < n && !found; i++) begin
      cnt = 0;
      for (int j = 0; j < n; j++) begin
        if (wrap_range(vals[j] - vals[i], rng) <= delta) begin
          cnt++;
        end
      end
      if (cnt - 1 == (n - 1) / 2) begin
        pivot = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      note_split_error();
      return;
    end
    store_slot(slot, 1 + vals[pivot]);
    half = rng / 2;
    lo = wrap_range(vals[pivot] + delta + 1, rng);
    ro = wrap_range(vals[pivot] + 1, rng);
    for (int i = 0; i < n; i++) begin
      d = wrap_range(vals[i] - lo, rng);
      if (d >= 0 && d < half && lefts.size() < MAX_ENTRIES) begin
        lefts.push_back(d);
      end
      d = wrap_range(vals[i] - ro, rng);
      if (d >= 0 && d < half && rights.size() < MAX_ENTRIES) begin
        rights.push_back(d);
      end
    end
    step = pow2_below(slot + 1);
    encode_node(half, lefts, slot + step);
    encode_node(delta, rights, slot + 2 * step);
  endfunction

  // Fold one accepted channel beat into the shadow state; a closing beat
  // builds the tree and queues all W slot beats.
  function automatic void absorb_channel(int ch, bit last);
    int sub;
    w_beat_t beat;
    if (ch == shadow_base) begin
      held_base_seen = 1'b1;
    end else if (held_entries.size() < MAX_ENTRIES) begin
      sub = shadow_form ? 1 : shadow_base + 1;
      held_entries.push_back(wrap_range(ch - sub, CHAN_SPAN));
    end else begin
      held_status = ST_OVERFLOW;
    end
    if (!last) begin
      return;
    end
    for (int k = 0; k < W_SLOTS; k++) begin
      tree_slots[k] = 0;
    end
    encode_node(shadow_range, held_entries, 0);
    if (held_status == ST_OVERFLOW) begin
      overflow_lists++;
    end else if (held_status == ST_NO_SPLIT) begin
      split_err_lists++;
    end
    for (int k = 0; k < W_SLOTS; k++) begin
      beat.w_value      = W_W'(tree_slots[k]);
      beat.w_slot       = SLOT_OUT_W'(k + 1);
      beat.last_result  = (k + 1 == W_SLOTS);
      beat.base_present = held_base_seen;
      beat.status       = held_status;
      expected_slots.push_back(beat);
    end
    held_entries.delete();
    held_base_seen = 1'b0;
    held_status = ST_OK;
    lists_closed++;
  endfunction

  // Send one channel beat. The valid line stays high inside a burst and is
  // dropped after the closing entry or when the burst runs out, followed
  // by a gap before the next beat, so it is never lowered and raised in the
  // same time step.
  task automatic send_channel(input int ch, input bit last);
    int gap;
    if (!list_ch.valid) begin
      list_ch.valid <= 1'b1;
    end
    list_ch.channel    <= CHAN_W'(ch);
    list_ch.last_entry <= last;
    do begin
      @(posedge clk);
    end while (!list_ch.ready);
    absorb_channel(ch, last);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end
    if (last || burst_left == 0) begin
      list_ch.valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 1;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 1000 : $urandom_range(1, 8);
    end
  endtask

  // Hold off until every queued W beat has been delivered.
  task automatic drain_results();
    while (expected_slots.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain_results();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    do begin
      @(posedge clk);
    end while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_TOP_RANGE:    shadow_range = value & 32'h7FF;
      REG_FORM_1024:    shadow_form  = value & 1;
      REG_BASE_CHANNEL: shadow_base  = value & 32'h3FF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input int rng, input int form, input int base);
    write_register(REG_TOP_RANGE, rng);
    write_register(REG_FORM_1024, form);
    write_register(REG_BASE_CHANNEL, base);
  endtask

  // Receiver: alternating calm stretches and stretches with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      w_ch.ready <= 1'b0;
      stall_left <= 0;
      calm_left  <= 40;
    end else if (calm_left > 0) begin
      w_ch.ready <= 1'b1;
      calm_left  <= calm_left - 1;
    end else if (stall_left > 0) begin
      w_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      w_ch.ready <= 1'b1;
      case ($urandom_range(0, 15))
        0:       calm_left  <= $urandom_range(20, 120);
        1, 2, 3: stall_left <= $urandom_range(1, 12);
        default: ;
      endcase
    end
  end

  // Result checker: each W beat is compared with the oldest expectation.
  always @(posedge clk) begin
    w_beat_t want;
    if (!rst && w_ch.valid && w_ch.ready) begin
      beats_checked++;
      if (expected_slots.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected W beat: slot %0d value %0d", w_ch.w_slot, w_ch.w_value);
        end
      end else begin
        want = expected_slots.pop_front();
        if (w_ch.w_value !== want.w_value || w_ch.w_slot !== want.w_slot ||
            w_ch.last_result !== want.last_result ||
            w_ch.base_present !== want.base_present || w_ch.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("W beat mismatch: expected value %0d slot %0d last %0b base %0b st %0d",
                     want.w_value, want.w_slot, want.last_result, want.base_present,
                     want.status);
            $display("                 actual   value %0d slot %0d last %0b base %0b st %0d",
                     w_ch.w_value, w_ch.w_slot, w_ch.last_result, w_ch.base_present,
                     w_ch.status);
          end
        end
      end
    end
  end

  // Watchdog: the limit sits well above the tree build of a full list
  // plus the longest receiver stall.
  always @(posedge clk) begin
    if (rst || (cfg.valid && cfg.ready) || (list_ch.valid && list_ch.ready) ||
        (w_ch.valid && w_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d W beats outstanding", expected_slots.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Directed lists: extremes of the channel field, the base channel being
  // dropped, an empty list, a single entry, both filtering forms and the
  // smallest and largest root ranges.
  task automatic test_directed();
    // Reset values: range 512, form 0, base 0.
    send_channel(0, 1'b1);
    send_channel(1023, 1'b1);
    send_channel(5, 1'b0);
    send_channel(0, 1'b0);
    send_channel(300, 1'b0);
    send_channel(1023, 1'b1);
    apply_setting(1024, 1, 1023);
    send_channel(1023, 1'b0);
    send_channel(0, 1'b0);
    send_channel(1, 1'b0);
    send_channel(512, 1'b0);
    send_channel(700, 1'b1);
    apply_setting(2, 0, 512);
    send_channel(513, 1'b0);
    send_channel(514, 1'b0);
    send_channel(515, 1'b1);
    apply_setting(1024, 0, 0);
    for (int i = 0; i < 7; i++) begin
      send_channel(i * 146 + 1, i == 6);
    end
  endtask

  // Lists longer than the entry store: the surplus is ignored and flagged.
  task automatic test_overflow();
    apply_setting(1024, 1, 200);
    for (int i = 0; i < 36; i++) begin
      send_channel((i * 29 + 3) % 1024, i == 35);
    end
  endtask

  // Random lists with random content; the setting changes every few lists.
  task automatic test_random_lists();
    int start_items;
    int len;
    int ch;
    int pick;
    int list_no;
    start_items = items_sent;
    list_no = 0;
    while (items_sent - start_items < RANDOM_ITEMS) begin
      if (list_no % 6 == 0) begin
        pick = $urandom_range(0, 5);
        apply_setting(pick == 0 ? 2 : pick == 1 ? 1024 : $urandom_range(2, 1024),
                      $urandom_range(0, 1), $urandom_range(0, 1023));
      end else if ($urandom_range(0, 7) == 0) begin
        drain_results();
      end
      pick = $urandom_range(0, 19);
      len = (pick < 17) ? $urandom_range(1, 10) :
            (pick < 19) ? $urandom_range(11, 32) : $urandom_range(33, 38);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 9))
          0:       ch = shadow_base;
          1:       ch = (shadow_base + $urandom_range(1, 3)) % 1024;
          2:       ch = ($urandom_range(0, 1) == 1) ? 1023 : 0;
          default: ch = $urandom_range(0, 1023);
        endcase
        send_channel(ch, i == len - 1);
      end
      list_no++;
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    list_ch.valid = 1'b0;
    list_ch.channel = '0;
    list_ch.last_entry = 1'b0;
    shadow_range = 512;
    shadow_form = 0;
    shadow_base = 0;
    held_base_seen = 1'b0;
    held_status = ST_OK;
    mismatches = 0;
    beats_checked = 0;
    lists_closed = 0;
    items_sent = 0;
    overflow_lists = 0;
    split_err_lists = 0;
    burst_left = 4;
    idle_cycles = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_overflow();
    test_random_lists();

    // Let every outstanding W beat arrive; the watchdog covers a hang.
    waited = 0;
    while (expected_slots.size() != 0 && waited < WATCHDOG_LIMIT * 4) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);

    $display("Covered %0d channel beats in %0d lists, %0d W beats checked.",
             items_sent, lists_closed, beats_checked);
    $display("Lists with overflow: %0d, with no split entry: %0d, mismatches: %0d.",
             overflow_lists, split_err_lists, mismatches);
    if (mismatches == 0 && expected_slots.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: arfcn_range_list_encoder.f
rtl/arl_pkg.sv
rtl/arl_if.sv
rtl/arl_scratch_ram.sv
rtl/arl_w_store.sv
rtl/arl_builder.sv
rtl/arfcn_range_list_encoder.sv
tb/tb_arfcn_range_list_encoder.sv
